>>> design/mwc_pkg.sv
// Shared types and constants for the multiply-with-carry bounded random unit.
`default_nettype none

package mwc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 5;

  localparam logic [15:0] ZMult = 16'd36969;
  localparam logic [15:0] WMult = 16'd18000;
  localparam logic [31:0] ZFixed = 32'h9068_ffff;
  localparam logic [31:0] WFixed = 32'h464f_ffff;
  localparam logic [31:0] AllOnes = 32'hffff_ffff;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BKT,
    ST_LIMIT,
    ST_DRAW,
    ST_CHECK,
    ST_VAL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> design/mwc_random_bounded_unit.sv
// Top level of the bounded multiply-with-carry random number unit.
//
// Each request word carries an interval; the unit answers with one 32-bit
// word that is uniform below the interval, or a raw draw when the interval
// is zero. Writing the 64-bit seed reloads both generator words (reset acts
// as a seed of zero). A raw draw passes through the draw, check and output
// states. A bounded request runs two divisions on one shared bit-serial
// divider, plus a limit multiply and a draw/check pair, and each rejected
// draw goes back to the draw state. The input is ready only while no
// request is in progress; a finished word waits in the output register
// while the next request is taken.
`default_nettype none

module mwc_random_bounded_unit import mwc_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire  [DataW-1:0] interval_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output logic [DataW-1:0] value_o,
  input  wire              cfg_we_i,
  input  wire  [63:0]      seed_value_i
);

  state_e           state_q, state_d;
  logic [DataW-1:0] ivl_q;
  logic [DataW-1:0] bkt_q;
  logic [DataW-1:0] limit_q;
  logic [DataW-1:0] res_q;
  logic [DataW-1:0] value_q;
  logic             out_valid_q;
  logic [DataW-1:0] draw;
  logic             advance;
  logic             in_acc;
  logic             load_out;
  logic             res_draw;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  mwc_gen u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_we_i (cfg_we_i),
    .seed_i    (seed_value_i),
    .advance_i (advance),
    .draw_o    (draw)
  );

  mwc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d          = state_q;
    advance          = 1'b0;
    load_out         = 1'b0;
    res_draw         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = AllOnes;
    div_req.divisor  = interval_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (interval_i == '0) begin
            state_d = ST_DRAW;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_BKT;
          end
        end
      end
      ST_BKT: begin
        if (div_rsp.done) begin
          state_d = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        state_d = ST_DRAW;
      end
      ST_DRAW: begin
        advance = 1'b1;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        div_req.dividend = draw;
        div_req.divisor  = bkt_q;
        priority if (ivl_q == '0) begin
          res_draw = 1'b1;
          state_d  = ST_OUT;
        end else if (draw >= limit_q) begin
          state_d = ST_DRAW;  // reject and draw again
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_VAL;
        end
      end
      ST_VAL: begin
        div_req.dividend = draw;
        div_req.divisor  = bkt_q;
        if (div_rsp.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ivl_q <= interval_i;
    end
    if (state_q == ST_BKT && div_rsp.done) begin
      bkt_q <= div_rsp.quotient;
    end
    if (state_q == ST_LIMIT) begin
      limit_q <= bkt_q * ivl_q;
    end
    if (res_draw) begin
      res_q <= draw;
    end else if (state_q == ST_VAL && div_rsp.done) begin
      res_q <= div_rsp.quotient;
    end
    if (load_out) begin
      value_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule

`default_nettype wire

>>> design/mwc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module mwc_div import mwc_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dvs_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DataW:0]   trial;

  // shift in the next dividend bit and try to subtract the divisor
  assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, dvs_q};

  always_comb begin
    if (!trial[DataW]) begin
      rem_d = trial[DataW-1:0];
      quo_d = {quo_q[DataW-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]};
      quo_d = {quo_q[DataW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !req_i.start && (cnt_q == {CntW{1'b1}});
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == {CntW{1'b1}}) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

>>> design/mwc_gen.sv
// Pair of lag-1 multiply-with-carry generators with seed load.
`default_nettype none

module mwc_gen import mwc_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              seed_we_i,
  input  wire  [63:0]      seed_i,
  input  wire              advance_i,
  output logic [DataW-1:0] draw_o
);

  logic [DataW-1:0] z_q, z_d;
  logic [DataW-1:0] w_q, w_d;
  logic [DataW-1:0] seed_lo, seed_hi;

  always_comb begin
    seed_lo = seed_i[31:0];
    seed_hi = seed_i[63:32];
    // bump the zero and fixed-point seeds
    if (seed_lo == '0 || seed_lo == WFixed) begin
      seed_lo = seed_lo + 32'd1;
    end
    if (seed_hi == '0 || seed_hi == ZFixed) begin
      seed_hi = seed_hi + 32'd1;
    end
  end

  assign z_d = ({16'd0, ZMult} * {16'd0, z_q[15:0]}) + {16'd0, z_q[31:16]};
  assign w_d = ({16'd0, WMult} * {16'd0, w_q[15:0]}) + {16'd0, w_q[31:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_q <= 32'd1;
      w_q <= 32'd1;
    end else if (seed_we_i) begin
      z_q <= seed_hi;
      w_q <= seed_lo;
    end else if (advance_i) begin
      z_q <= z_d;
      w_q <= w_d;
    end
  end

  assign draw_o = {z_q[15:0], 16'd0} + w_q;

endmodule

`default_nettype wire

>>> tb/tb_mwc_random_bounded_unit.sv
// Self-checking testbench for the bounded multiply-with-carry random unit.
`timescale 1ns / 100ps

module tb_mwc_random_bounded_unit;
  import mwc_pkg::*;

  localparam bit [31:0] GenZMul   = 32'd36969;
  localparam bit [31:0] GenWMul   = 32'd18000;
  localparam bit [31:0] LowMask   = 32'h0000_ffff;
  localparam bit [31:0] GenZFixed = 32'h9068_ffff;
  localparam bit [31:0] GenWFixed = 32'h464f_ffff;
  localparam bit [31:0] FullRange = 32'hffff_ffff;
  localparam bit [31:0] RawDraw   = 32'd0;

  localparam int ResetCycles   = 11;
  localparam int DrainTail     = 8;
  localparam int HoldOffCycles = 600;
  localparam int PhaseWords    = 310;

  class draw_scoreboard;
    bit [31:0] gen_z;
    bit [31:0] gen_w;
    bit [31:0] expected_words[$];
    int        mismatches;
    int        requests;
    int        raw_requests;
    int        redraws;

    function new();
      mismatches   = 0;
      requests     = 0;
      raw_requests = 0;
      redraws      = 0;
      load_seed(64'd0);
    endfunction

    // Split the seed and bump forbidden words (zero or the generator's fixed point).
    function void load_seed(bit [63:0] seed);
      bit [31:0] lo;
      bit [31:0] hi;
      lo = seed[31:0];
      hi = seed[63:32];
      if (lo == 32'd0 || lo == GenWFixed) lo = lo + 32'd1;
      if (hi == 32'd0 || hi == GenZFixed) hi = hi + 32'd1;
      gen_w = lo;
      gen_z = hi;
    endfunction

    function bit [31:0] advance();
      gen_z = GenZMul * (gen_z & LowMask) + (gen_z >> 16);
      gen_w = GenWMul * (gen_w & LowMask) + (gen_w >> 16);
      return (gen_z << 16) + gen_w;
    endfunction

    function void note_request(bit [31:0] interval);
      bit [31:0] buckets;
      bit [31:0] limit;
      bit [31:0] word;
      requests++;
      if (interval == RawDraw) begin
        raw_requests++;
        expected_words.push_back(advance());
      end else begin
        buckets = FullRange / interval;
        limit   = buckets * interval;
        word    = advance();
        // Redraw until the draw falls below the last full bucket.
        while (word >= limit) begin
          redraws++;
          word = advance();
        end
        expected_words.push_back(word / buckets);
      end
    endfunction

    task report_mismatch(string what, bit [31:0] got, bit [31:0] want);
      mismatches++;
      $display("MISMATCH at %0t ns: %s got %08h want %08h", $time, what, got, want);
    endtask

    task check_word(bit [31:0] got);
      bit [31:0] want;
      if (expected_words.size() == 0) begin
        report_mismatch("value_o with no request pending", got, 32'd0);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) report_mismatch("value_o", got, want);
      end
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [DataW-1:0] interval_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [DataW-1:0] value_o;
  logic             cfg_we_i;
  logic [63:0]      seed_value_i;

  draw_scoreboard draws = new();

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int rx_holdoff   = 0;
  int seed_loads   = 0;

  mwc_random_bounded_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .interval_i   (interval_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .cfg_we_i     (cfg_we_i),
    .seed_value_i (seed_value_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("mwc_random_bounded_unit test failed");
    $finish;
  end

  // Output side: check each accepted word, then pick the next ready level.
  initial begin
    int stall;
    stall = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) draws.check_word(value_o);
      if (rx_holdoff > 0) begin
        stall      = rx_holdoff;
        rx_holdoff = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if ($urandom_range(99) < rx_stall_pct) begin
        out_ready_i <= 1'b0;
        stall = ($urandom_range(7) == 0) ? $urandom_range(150, 20) : $urandom_range(3, 0);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_interval(bit [31:0] interval);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct)
      gap = ($urandom_range(3) == 0) ? $urandom_range(90, 1) : $urandom_range(4, 1);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    interval_i <= interval;
    do @(posedge clk_i); while (!in_ready_o);
    draws.note_request(interval);
  endtask

  // Drop valid and wait until every expected word is out.
  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (draws.pending() != 0) @(posedge clk_i);
    repeat (DrainTail) @(posedge clk_i);
  endtask

  task automatic write_seed(bit [63:0] seed);
    cfg_we_i     <= 1'b1;
    seed_value_i <= seed;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    draws.load_seed(seed);
    seed_loads++;
  endtask

  function automatic bit [31:0] random_interval();
    case ($urandom_range(9))
      0:       return RawDraw;
      1:       return 32'd1;
      2:       return $urandom_range(16, 2);
      3:       return $urandom_range(65535, 17);
      4:       return 32'h8000_0000 + $urandom_range(15, 0);
      5:       return 32'h7fff_fff0 + $urandom_range(15, 0);
      6:       return FullRange - $urandom_range(15, 0);
      default: return $urandom();
    endcase
  endfunction

  task automatic run_phase(int tx_pct, int rx_pct, bit hold_off, bit mid_pause, int count);
    int i;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    write_seed({$urandom(), $urandom()});
    if (hold_off) rx_holdoff = HoldOffCycles;
    for (i = 0; i < count; i++) begin
      if (mid_pause && i == count / 2) drain_words();
      send_interval(random_interval());
    end
    drain_words();
  endtask

  initial begin
    bit [31:0] reset_intervals[10];
    int i;
    reset_intervals = '{RawDraw, 32'd1, 32'd2, 32'd3, FullRange, 32'h8000_0000,
                        32'h8000_0001, 32'h7fff_ffff, 32'h0000_ffff, 32'h0001_0000};
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    interval_i   <= '0;
    cfg_we_i     <= 1'b0;
    seed_value_i <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset seed, interval extremes and the worst rejection rate.
    for (i = 0; i < 10; i++) send_interval(reset_intervals[i]);
    drain_words();

    // This seed makes the first draw all ones: rejected for an interval of one.
    write_seed({32'hffff_0000, 32'hffff_0000});
    send_interval(32'd1);
    send_interval(RawDraw);
    send_interval(32'd1);
    drain_words();
    write_seed({32'hffff_0000, 32'hffff_0000});
    send_interval(RawDraw);
    drain_words();

    // Fixed points, words above them, and zero halves.
    write_seed({GenZFixed, GenWFixed});
    send_interval(RawDraw);
    send_interval(32'd7);
    drain_words();
    write_seed(64'hffff_ffff_ffff_ffff);
    send_interval(RawDraw);
    send_interval(FullRange);
    drain_words();
    write_seed(64'd0);
    send_interval(RawDraw);
    send_interval(32'd100);
    drain_words();
    write_seed({GenZFixed, 32'd0});
    send_interval(RawDraw);
    drain_words();

    run_phase(0, 0, 1'b0, 1'b0, PhaseWords);
    run_phase(60, 0, 1'b0, 1'b1, PhaseWords);
    run_phase(0, 60, 1'b1, 1'b0, PhaseWords);
    run_phase(19, 19, 1'b0, 1'b0, PhaseWords);

    $display("Covered %0d requests (%0d raw, %0d bounded) with %0d rejected draws",
             draws.requests, draws.raw_requests, draws.requests - draws.raw_requests,
             draws.redraws);
    $display("%0d seed loads incl. forbidden words; idle mixes plus a %0d-cycle output hold",
             seed_loads, HoldOffCycles);
    if (draws.mismatches == 0 && draws.pending() == 0) begin
      $display("mwc_random_bounded_unit test passed");
    end else begin
      $display("mwc_random_bounded_unit test failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/mwc_pkg.sv
design/mwc_div.sv
design/mwc_gen.sv
design/mwc_random_bounded_unit.sv
tb/tb_mwc_random_bounded_unit.sv
